/* rtl/rtc_i2c_pkg.sv */
// Types, codes and helper functions for the RTC I2C time transfer block.
// No dependencies; used by the sequencer, the top level and the testbench.
package rtc_i2c_pkg;

  typedef enum logic [1:0] {
    OP_IDLE = 2'd0,
    OP_READ = 2'd1,
    OP_SET  = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    K_START     = 3'd0,
    K_WRITE     = 3'd1,
    K_READ_ACK  = 3'd2,
    K_READ_NACK = 3'd3,
    K_STOP      = 3'd4
  } kind_t;

  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_READ = 2'd1;
  localparam logic [1:0] CMD_SET  = 2'd2;

  localparam logic [6:0] ADDR_RESET = 7'd104;
  localparam logic [3:0] READ_STEPS = 4'd13;
  localparam logic [3:0] SET_STEPS  = 4'd11;
  localparam logic [4:0] BIT_PHASES = 5'd16;
  localparam logic [4:0] BYTE_LEN   = 5'd17;
  localparam logic [4:0] EDGE_LEN   = 5'd2;
  localparam logic [7:0] REG_ZERO   = 8'h00;
  localparam logic [7:0] SEC_MASK   = 8'h7F;
  localparam logic [7:0] HOUR_MASK  = 8'h3F;
  localparam int         NUM_BYTES  = 7;

  typedef struct packed {
    logic [1:0] command;
    logic       sda_in;
    logic [5:0] set_seconds;
    logic [5:0] set_minutes;
    logic [4:0] set_hours;
    logic [2:0] set_weekday;
    logic [4:0] set_day;
    logic [3:0] set_month;
    logic [6:0] set_year;
  } item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [6:0] got_seconds;
    logic [7:0] got_minutes;
    logic [5:0] got_hours;
    logic [7:0] got_weekday;
    logic [7:0] got_day;
    logic [7:0] got_month;
    logic [7:0] got_year;
  } result_t;

  // binary to packed BCD; tens = (v * 205) >> 11 is exact for v < 1029
  function automatic logic [7:0] dec_bcd(input logic [6:0] v);
    logic [14:0] prod;
    logic [3:0]  q;
    logic [6:0]  r;
    prod = 15'(v) * 15'd205;
    q    = prod[14:11];
    r    = v - 7'(7'(q) * 7'd10);
    return {q, r[3:0]};
  endfunction

  // packed BCD to binary, non-BCD nibbles pass through the same formula
  function automatic logic [7:0] bcd_dec(input logic [7:0] v);
    return 8'(8'(v[7:4]) * 8'd10) + 8'(v[3:0]);
  endfunction

  function automatic kind_t kind_of(input op_t op, input logic [3:0] s);
    kind_t k;
    k = K_STOP;
    case (op)
      OP_READ: begin
        if (s == 4'd0 || s == 4'd3) k = K_START;
        else if (s == 4'd1 || s == 4'd2 || s == 4'd4) k = K_WRITE;
        else if (s >= 4'd5 && s <= 4'd10) k = K_READ_ACK;
        else if (s == 4'd11) k = K_READ_NACK;
        else k = K_STOP;
      end
      default: begin
        if (s == 4'd0) k = K_START;
        else if (s >= 4'd1 && s <= 4'd9) k = K_WRITE;
        else k = K_STOP;
      end
    endcase
    return k;
  endfunction

endpackage

/* rtl/rtc_i2c_cmd_if.sv */
// Request channel carrying one bus tick and its command fields.
// Depends on nothing; payload names match the block's input fields.
interface rtc_i2c_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic       sda_in;
  logic [5:0] set_seconds;
  logic [5:0] set_minutes;
  logic [4:0] set_hours;
  logic [2:0] set_weekday;
  logic [4:0] set_day;
  logic [3:0] set_month;
  logic [6:0] set_year;

  modport source (
    output valid, command, sda_in, set_seconds, set_minutes, set_hours,
           set_weekday, set_day, set_month, set_year,
    input  ready
  );
  modport sink (
    input  valid, command, sda_in, set_seconds, set_minutes, set_hours,
           set_weekday, set_day, set_month, set_year,
    output ready
  );
endinterface

/* rtl/rtc_i2c_rsp_if.sv */
// Result channel carrying line levels, status and the decoded time.
// Depends on nothing; payload names match the block's output fields.
interface rtc_i2c_rsp_if;
  logic       valid;
  logic       ready;
  logic       scl_out;
  logic       sda_out;
  logic       busy_res;
  logic       done_res;
  logic [6:0] got_seconds;
  logic [7:0] got_minutes;
  logic [5:0] got_hours;
  logic [7:0] got_weekday;
  logic [7:0] got_day;
  logic [7:0] got_month;
  logic [7:0] got_year;

  modport source (
    output valid, scl_out, sda_out, busy_res, done_res, got_seconds,
           got_minutes, got_hours, got_weekday, got_day, got_month, got_year,
    input  ready
  );
  modport sink (
    input  valid, scl_out, sda_out, busy_res, done_res, got_seconds,
           got_minutes, got_hours, got_weekday, got_day, got_month, got_year,
    output ready
  );
endinterface

/* rtl/rtc_i2c_cfg_if.sv */
// Configuration write channel for the seven-bit device address.
// Depends on nothing.
interface rtc_i2c_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

/* rtl/rtc_i2c_seq.sv */
// Bus sequencer: transaction state, shift register, time bytes, BCD paths.
// Advances one tick per step; depends on rtc_i2c_pkg.
module rtc_i2c_seq
  import rtc_i2c_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  item_t      item,
  input  logic [6:0] dev_addr,
  output result_t    result
);

  op_t        operation;
  logic [3:0] step_index;
  logic [4:0] phase_count;
  logic [7:0] shift_byte;
  logic [1:0] line_levels;
  logic [7:0] time_bytes [NUM_BYTES];
  logic [7:0] set_latch  [NUM_BYTES];

  op_t        operation_next;
  logic [3:0] step_index_next;
  logic [4:0] phase_count_next;
  logic [7:0] shift_byte_next;
  logic [1:0] line_levels_next;

  logic       start, latch_we, tb_we;
  op_t        cur_op;
  logic [3:0] s, last_step, s_inc;
  logic [4:0] p, p_inc, len;
  kind_t      kind;
  logic [7:0] wr_byte, sb_eff, raw, tb_val;
  logic [2:0] tb_idx, latch_idx;
  logic       scl, sda, busy, done;
  logic [7:0] tb_view [NUM_BYTES];
  logic [7:0] addr_byte;

  assign addr_byte = {dev_addr, 1'b0};
  assign latch_idx = 3'(s - 4'd3);

  always_comb begin
    start    = (operation == OP_IDLE) &&
               (item.command == CMD_READ || item.command == CMD_SET);
    latch_we = start && (item.command == CMD_SET);
    cur_op   = start ? op_t'(item.command) : operation;
    s        = start ? 4'd0 : step_index;
    p        = start ? 5'd0 : phase_count;
    kind     = kind_of(cur_op, s);
    len      = (kind == K_START || kind == K_STOP) ? EDGE_LEN : BYTE_LEN;
    last_step = (cur_op == OP_READ) ? READ_STEPS : SET_STEPS;

    if (s == 4'd1) wr_byte = addr_byte;
    else if (s == 4'd2) wr_byte = REG_ZERO;
    else if (cur_op == OP_READ) wr_byte = addr_byte | 8'h01;
    else if (s >= 4'd3 && s <= 4'd9) wr_byte = set_latch[latch_idx];
    else wr_byte = REG_ZERO;

    scl = line_levels[1];
    sda = line_levels[0];
    busy = 1'b0;
    done = 1'b0;
    shift_byte_next = shift_byte;
    tb_we  = 1'b0;
    tb_idx = 3'(s - 4'd5);
    raw    = shift_byte;
    tb_val = bcd_dec(raw);
    sb_eff = shift_byte;
    operation_next   = cur_op;
    step_index_next  = s;
    phase_count_next = p;
    p_inc = p + 5'd1;
    s_inc = s + 4'd1;

    if (cur_op != OP_IDLE) begin
      busy = 1'b1;
      case (kind)
        K_START: begin
          scl = 1'b1;
          sda = (p == 5'd0);
        end
        K_STOP: begin
          scl = 1'b1;
          sda = (p != 5'd0);
        end
        K_WRITE: begin
          sb_eff = (p == 5'd0) ? wr_byte : shift_byte;
          shift_byte_next = sb_eff;
          if (p < BIT_PHASES) begin
            scl = p[0];
            sda = sb_eff[~p[3:1]];
          end else begin
            scl = 1'b1;
            sda = 1'b1;
          end
        end
        default: begin
          // read byte, with ACK or NACK
          sb_eff = (p == 5'd0) ? 8'h00 : shift_byte;
          shift_byte_next = sb_eff;
          if (p < BIT_PHASES) begin
            scl = ~p[0];
            sda = 1'b1;
            if (!p[0]) shift_byte_next = {sb_eff[6:0], item.sda_in};
          end else begin
            scl = 1'b1;
            sda = (kind == K_READ_NACK);
            raw = sb_eff;
            if (tb_idx == 3'd0) raw = sb_eff & SEC_MASK;
            if (tb_idx == 3'd2) raw = sb_eff & HOUR_MASK;
            tb_val = bcd_dec(raw);
            tb_we  = (tb_idx != 3'd7);
          end
        end
      endcase

      phase_count_next = p_inc;
      if (p_inc >= len) begin
        phase_count_next = 5'd0;
        step_index_next  = s_inc;
        if (s_inc >= last_step) begin
          operation_next  = OP_IDLE;
          step_index_next = 4'd0;
          done = 1'b1;
        end
      end
    end

    line_levels_next = {scl, sda};
  end

  always_comb begin
    for (int i = 0; i < NUM_BYTES; i++) begin
      tb_view[i] = (tb_we && tb_idx == 3'(i)) ? tb_val : time_bytes[i];
    end
  end

  always_comb begin
    result.scl_out     = scl;
    result.sda_out     = sda;
    result.busy_res    = busy;
    result.done_res    = done;
    result.got_seconds = tb_view[0][6:0];
    result.got_minutes = tb_view[1];
    result.got_hours   = tb_view[2][5:0];
    result.got_weekday = tb_view[3];
    result.got_day     = tb_view[4];
    result.got_month   = tb_view[5];
    result.got_year    = tb_view[6];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      operation   <= OP_IDLE;
      step_index  <= 4'd0;
      phase_count <= 5'd0;
      line_levels <= 2'b11;
      for (int i = 0; i < NUM_BYTES; i++) time_bytes[i] <= 8'h00;
    end else if (step) begin
      operation   <= operation_next;
      step_index  <= step_index_next;
      phase_count <= phase_count_next;
      line_levels <= line_levels_next;
      if (tb_we) time_bytes[tb_idx] <= tb_val;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (step) begin
      shift_byte <= shift_byte_next;
      if (latch_we) begin
        set_latch[0] <= dec_bcd(7'(item.set_seconds));
        set_latch[1] <= dec_bcd(7'(item.set_minutes));
        set_latch[2] <= dec_bcd(7'(item.set_hours));
        set_latch[3] <= dec_bcd(7'(item.set_weekday));
        set_latch[4] <= dec_bcd(7'(item.set_day));
        set_latch[5] <= dec_bcd(7'(item.set_month));
        set_latch[6] <= item.set_year == 7'd0 ? 8'h00 : dec_bcd(item.set_year);
      end
    end
  end

endmodule

/* rtl/rtc_i2c_time_transfer_core.sv */
// Top level of the RTC I2C time transfer block: request register, sequencer,
// result register and the device address register. Depends on rtc_i2c_pkg,
// the three channel interfaces and rtc_i2c_seq.
//
//   channel  role    payload
//   cmd      sink    command, sda_in, set_* (one bus tick per request)
//   rsp      source  scl_out, sda_out, busy_res, done_res, got_*
//   cfg      sink    data: seven-bit device address, always ready
//
// One request per cycle sustained while the result is taken; each request yields one
// result through the request register, then the result register.
// Reset (rst, synchronous) leaves the bus idle with both lines released,
// the address at 104 and the decoded time at zero.
// A stalled result holds the request register; cmd.ready drops only when
// both registers are full and rsp.ready is low.
module rtc_i2c_time_transfer_core
  import rtc_i2c_pkg::*;
(
  input  logic clk,
  input  logic rst,
  rtc_i2c_cmd_if.sink   cmd,
  rtc_i2c_rsp_if.source rsp,
  rtc_i2c_cfg_if.sink   cfg
);

  logic       req_valid;
  item_t      req_item;
  logic       rsp_valid;
  result_t    rsp_data;
  logic [6:0] dev_addr;
  logic       advance;
  result_t    seq_result;
  item_t      cmd_item;

  assign advance   = req_valid && (!rsp_valid || rsp.ready);
  assign cmd.ready = !req_valid || advance;
  assign cfg.ready = 1'b1;

  always_comb begin
    cmd_item.command     = cmd.command;
    cmd_item.sda_in      = cmd.sda_in;
    cmd_item.set_seconds = cmd.set_seconds;
    cmd_item.set_minutes = cmd.set_minutes;
    cmd_item.set_hours   = cmd.set_hours;
    cmd_item.set_weekday = cmd.set_weekday;
    cmd_item.set_day     = cmd.set_day;
    cmd_item.set_month   = cmd.set_month;
    cmd_item.set_year    = cmd.set_year;
  end

  rtc_i2c_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .step     (advance),
    .item     (req_item),
    .dev_addr (dev_addr),
    .result   (seq_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      rsp_valid <= 1'b0;
      dev_addr  <= ADDR_RESET;
    end else begin
      if (cmd.valid && cmd.ready) req_valid <= 1'b1;
      else if (advance) req_valid <= 1'b0;

      if (advance) rsp_valid <= 1'b1;
      else if (rsp.ready) rsp_valid <= 1'b0;

      if (cfg.valid && cfg.ready) dev_addr <= cfg.data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) req_item <= cmd_item;
    if (advance) rsp_data <= seq_result;
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.scl_out     = rsp_data.scl_out;
  assign rsp.sda_out     = rsp_data.sda_out;
  assign rsp.busy_res    = rsp_data.busy_res;
  assign rsp.done_res    = rsp_data.done_res;
  assign rsp.got_seconds = rsp_data.got_seconds;
  assign rsp.got_minutes = rsp_data.got_minutes;
  assign rsp.got_hours   = rsp_data.got_hours;
  assign rsp.got_weekday = rsp_data.got_weekday;
  assign rsp.got_day     = rsp_data.got_day;
  assign rsp.got_month   = rsp_data.got_month;
  assign rsp.got_year    = rsp_data.got_year;

endmodule

/* verif/tb.sv */
// Testbench for rtc_i2c_time_transfer_core: drives bus ticks and address writes, predicts
// every tick's line levels, status and decoded time, and checks them in a scoreboard class.
// Depends on rtc_i2c_pkg, the three channel interfaces and the core.
`timescale 1ns / 100ps

module tb;
  import rtc_i2c_pkg::*;

  localparam logic [1:0] CMD_SPARE = 2'd3;  // unused code, acts as a plain tick

  class time_scoreboard;
    op_t        op;
    int         step;
    int         phase;
    logic [7:0] shreg;
    logic       scl_q;
    logic       sda_q;
    logic [7:0] regs[NUM_BYTES];
    logic [7:0] set_bcd[NUM_BYTES];
    logic [6:0] addr;
    result_t    want_q[$];
    int         errors;

    function new();
      op     = OP_IDLE;
      step   = 0;
      phase  = 0;
      shreg  = '0;
      scl_q  = 1'b1;
      sda_q  = 1'b1;
      addr   = ADDR_RESET;
      errors = 0;
      foreach (regs[i]) begin
        regs[i]    = '0;
        set_bcd[i] = '0;
      end
    endfunction

    function logic [7:0] to_bcd(int v);
      return 8'(((v / 10) << 4) | (v % 10));
    endfunction

    function logic [7:0] from_bcd(logic [7:0] b);
      return 8'(int'(b[7:4]) * 10 + int'(b[3:0]));
    endfunction

    function kind_t step_kind(int s);
      if (op == OP_READ) begin
        case (s)
          0, 3:         return K_START;
          1, 2, 4:      return K_WRITE;
          5, 6, 7, 8, 9, 10: return K_READ_ACK;
          11:           return K_READ_NACK;
          default:      return K_STOP;
        endcase
      end
      if (s == 0) return K_START;
      if (s <= 9) return K_WRITE;
      return K_STOP;
    endfunction

    function logic [7:0] byte_for(int s);
      if (s == 1) return {addr, 1'b0};
      if (s == 2) return REG_ZERO;
      if (op == OP_READ) return {addr, 1'b1};
      return set_bcd[s - 3];
    endfunction

    function bit is_idle();
      return op == OP_IDLE;
    endfunction

    function int pending();
      return want_q.size();
    endfunction

    // advance the bus sequencer by one accepted tick and queue its result
    function void note_request(item_t it);
      result_t    r;
      kind_t      k;
      int         p, s, len, last, idx;
      logic       scl, sda;
      logic [7:0] raw;
      r = '0;
      if (op == OP_IDLE && (it.command == CMD_READ || it.command == CMD_SET)) begin
        op    = (it.command == CMD_READ) ? OP_READ : OP_SET;
        step  = 0;
        phase = 0;
        if (op == OP_SET) begin
          set_bcd[0] = to_bcd(it.set_seconds);
          set_bcd[1] = to_bcd(it.set_minutes);
          set_bcd[2] = to_bcd(it.set_hours);
          set_bcd[3] = to_bcd(it.set_weekday);
          set_bcd[4] = to_bcd(it.set_day);
          set_bcd[5] = to_bcd(it.set_month);
          set_bcd[6] = to_bcd(it.set_year);
        end
      end
      scl = scl_q;
      sda = sda_q;
      if (op != OP_IDLE) begin
        s    = step;
        p    = phase;
        k    = step_kind(s);
        len  = (k == K_START || k == K_STOP) ? int'(EDGE_LEN) : int'(BYTE_LEN);
        last = (op == OP_READ) ? int'(READ_STEPS) : int'(SET_STEPS);
        r.busy_res = 1'b1;
        case (k)
          K_START: begin
            scl = 1'b1;
            sda = (p == 0);
          end
          K_STOP: begin
            scl = 1'b1;
            sda = (p != 0);
          end
          K_WRITE: begin
            if (p == 0) shreg = byte_for(s);
            if (p < 16) begin
              scl = p[0];
              sda = shreg[7 - p / 2];
            end else begin
              scl = 1'b1;
              sda = 1'b1;
            end
          end
          default: begin
            if (p == 0) shreg = '0;
            if (p < 16) begin
              scl = !p[0];
              sda = 1'b1;
              if (!p[0]) shreg = {shreg[6:0], it.sda_in};
            end else begin
              // ACK/NACK tick: store the finished byte
              idx = s - 5;
              raw = shreg;
              scl = 1'b1;
              sda = (k == K_READ_NACK);
              if (idx == 0) raw &= SEC_MASK;
              if (idx == 2) raw &= HOUR_MASK;
              regs[idx] = from_bcd(raw);
            end
          end
        endcase
        p++;
        if (p >= len) begin
          p = 0;
          s++;
          if (s >= last) begin
            op = OP_IDLE;
            s  = 0;
            r.done_res = 1'b1;
          end
        end
        phase = p;
        step  = s;
      end
      scl_q         = scl;
      sda_q         = sda;
      r.scl_out     = scl;
      r.sda_out     = sda;
      r.got_seconds = regs[0][6:0];
      r.got_minutes = regs[1];
      r.got_hours   = regs[2][5:0];
      r.got_weekday = regs[3];
      r.got_day     = regs[4];
      r.got_month   = regs[5];
      r.got_year    = regs[6];
      want_q.push_back(r);
    endfunction

    function void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t w;
      if (want_q.size() == 0) begin
        $error("result with no request pending");
        errors++;
        return;
      end
      w = want_q.pop_front();
      check_field("scl_out", w.scl_out, got.scl_out);
      check_field("sda_out", w.sda_out, got.sda_out);
      check_field("busy_res", w.busy_res, got.busy_res);
      check_field("done_res", w.done_res, got.done_res);
      check_field("got_seconds", w.got_seconds, got.got_seconds);
      check_field("got_minutes", w.got_minutes, got.got_minutes);
      check_field("got_hours", w.got_hours, got.got_hours);
      check_field("got_weekday", w.got_weekday, got.got_weekday);
      check_field("got_day", w.got_day, got.got_day);
      check_field("got_month", w.got_month, got.got_month);
      check_field("got_year", w.got_year, got.got_year);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  bit   calm;
  int   hold_left;
  time_scoreboard sb;

  rtc_i2c_cmd_if cmd_ch();
  rtc_i2c_rsp_if rsp_ch();
  rtc_i2c_cfg_if cfg_ch();

  rtc_i2c_time_transfer_core dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #400000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // receiver: random stalls, or a long hold-off when asked
  always @(negedge clk) begin
    if (hold_left > 0) begin
      rsp_ch.ready <= 1'b0;
      hold_left--;
    end else begin
      rsp_ch.ready <= calm || ($urandom_range(99) >= 6);
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      sb.check_result('{rsp_ch.scl_out, rsp_ch.sda_out, rsp_ch.busy_res, rsp_ch.done_res,
                        rsp_ch.got_seconds, rsp_ch.got_minutes, rsp_ch.got_hours,
                        rsp_ch.got_weekday, rsp_ch.got_day, rsp_ch.got_month,
                        rsp_ch.got_year});
    end
  end

  function automatic item_t make_tick(logic [1:0] c, logic sda);
    item_t it;
    it             = item_t'({$urandom, $urandom});
    it.command     = c;
    it.sda_in      = sda;
    return it;
  endfunction

  // offer one tick at the falling edge; returns at the falling edge after acceptance
  task automatic push_tick(input item_t it);
    if (!calm) begin
      while ($urandom_range(99) < 6) begin
        cmd_ch.valid <= 1'b0;
        @(negedge clk);
      end
    end
    cmd_ch.valid       <= 1'b1;
    cmd_ch.command     <= it.command;
    cmd_ch.sda_in      <= it.sda_in;
    cmd_ch.set_seconds <= it.set_seconds;
    cmd_ch.set_minutes <= it.set_minutes;
    cmd_ch.set_hours   <= it.set_hours;
    cmd_ch.set_weekday <= it.set_weekday;
    cmd_ch.set_day     <= it.set_day;
    cmd_ch.set_month   <= it.set_month;
    cmd_ch.set_year    <= it.set_year;
    do @(posedge clk); while (!cmd_ch.ready);
    sb.note_request(it);
    @(negedge clk);
  endtask

  // one whole transaction; sda_mode 0/1 forces the line, 2 is random.
  // filler is the command sent on every busy tick (ignored by the block).
  task automatic run_transfer(input item_t first, input int sda_mode, input logic [1:0] filler);
    logic sda;
    push_tick(first);
    while (!sb.is_idle()) begin
      sda = (sda_mode == 2) ? 1'($urandom_range(1)) : 1'(sda_mode);
      push_tick(make_tick(filler, sda));
    end
  endtask

  // finish the bus transfer, drain results, then write the address
  task automatic write_address(input logic [6:0] v);
    while (!sb.is_idle()) push_tick(make_tick(CMD_TICK, 1'($urandom_range(1))));
    cmd_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.addr = v;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic random_ticks(input int n);
    int          r;
    logic [1:0]  c;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (sb.is_idle())
        c = (r < 45) ? CMD_READ : (r < 90) ? CMD_SET : (r < 95) ? CMD_SPARE : CMD_TICK;
      else
        c = (r < 5) ? 2'($urandom_range(1, 3)) : CMD_TICK;
      push_tick(make_tick(c, 1'($urandom_range(1))));
    end
  endtask

  initial begin
    item_t it;
    sb                 = new();
    calm               = 1'b0;
    hold_left          = 0;
    rst                = 1'b1;
    cmd_ch.valid       = 1'b0;
    cmd_ch.command     = CMD_TICK;
    cmd_ch.sda_in      = 1'b0;
    cmd_ch.set_seconds = '0;
    cmd_ch.set_minutes = '0;
    cmd_ch.set_hours   = '0;
    cmd_ch.set_weekday = '0;
    cmd_ch.set_day     = '0;
    cmd_ch.set_month   = '0;
    cmd_ch.set_year    = '0;
    rsp_ch.ready       = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.data        = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // idle ticks, including the spare code
    push_tick(make_tick(CMD_TICK, 1'b0));
    push_tick(make_tick(CMD_SPARE, 1'b1));
    // a read of all-ones bytes (non-BCD, masks matter) with commands spammed
    // while busy, then a read of all-zero bytes right on the tick after completion
    run_transfer(make_tick(CMD_READ, 1'b1), 1, CMD_SET);
    run_transfer(make_tick(CMD_READ, 1'b0), 0, CMD_READ);

    write_address(7'h7F);
    it = make_tick(CMD_SET, 1'b1);
    it.set_seconds = '1; it.set_minutes = '1; it.set_hours = '1; it.set_weekday = '1;
    it.set_day = '1; it.set_month = '1; it.set_year = '1;
    run_transfer(it, 2, CMD_TICK);
    it = make_tick(CMD_SET, 1'b0);
    it.set_seconds = '0; it.set_minutes = '0; it.set_hours = '0; it.set_weekday = '0;
    it.set_day = '0; it.set_month = '0; it.set_year = '0;
    run_transfer(it, 2, CMD_SPARE);

    write_address(7'h00);
    run_transfer(make_tick(CMD_READ, 1'b1), 2, CMD_TICK);

    // random traffic over several addresses; a long result stall in the first phase
    write_address(7'($urandom_range(127)));
    random_ticks(60);
    hold_left = 80;
    random_ticks(100);
    write_address(ADDR_RESET);
    calm = 1'b1;
    random_ticks(150);
    calm = 1'b0;
    write_address(7'($urandom_range(127)));
    random_ticks(50);
    write_address(7'($urandom_range(127)));
    random_ticks(50);

    cmd_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
